### design/adaptive_frame_wake_scheduler_assert.svh
// Assertion macros shared by the checker of the adaptive frame wake scheduler.
// No dependencies; take it in with `include before the assertions are written.
`ifndef ADAPTIVE_FRAME_WAKE_SCHEDULER_ASSERT_SVH
`define ADAPTIVE_FRAME_WAKE_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adaptive_frame_wake_scheduler: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AFWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adaptive_frame_wake_scheduler: assertion failed");

`endif

### design/afws_pkg.sv
// Package of the adaptive frame wake scheduler: widths, reset values,
// register indexes and the sequencer state type. No dependencies.
package afws_pkg;

    localparam int TIME_W   = 64;
    localparam int NS_W     = 32;
    localparam int IDX_W    = 2;
    localparam int DIV_STEPS = TIME_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [NS_W-1:0] MIN_MARGIN_RST = 32'd500000;
    localparam logic [NS_W-1:0] STEP_UP_RST    = 32'd250000;
    localparam logic [NS_W-1:0] STEP_DOWN_RST  = 32'd10000;
    localparam logic [NS_W-1:0] MARGIN_RST     = 32'd500000;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_MARGIN = 2'd0,
        REG_STEP_UP    = 2'd1,
        REG_STEP_DOWN  = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_MARGIN,
        ST_BUDGET,
        ST_REACH,
        ST_DIFF,
        ST_DIV,
        ST_SUB_REM,
        ST_ADD_PERIOD,
        ST_WAKE,
        ST_SLEEP,
        ST_DONE
    } state_t;

endpackage

### design/adaptive_frame_wake_scheduler.sv
// Adaptive frame wake scheduler: top level with sequencer and bit-serial divider.
// Depends on afws_pkg.
//
// Usage
//   Input channel (in_valid / in_stall): one transfer per display frame with the
//   current time, refresh period, last scanout, pipeline and photon estimates
//   and the missed-refresh count. in_stall is high while an item is in work.
//   Output channel (out_valid / out_stall): exactly one result per item, held in
//   an output register; a stalled result stays put, and the next item may be
//   taken while it waits.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; indexes
//   0..2 select min_margin, margin_step_up and margin_step_down, index 3 is
//   ignored. Write only while the block is idle.
// Operation
//   An item with a zero hint goes straight to the output stage and gives a
//   result without pacing. When now plus budget lies beyond the last scanout,
//   the remainder of the distance by the period is found by a restoring divider
//   retiring one quotient bit per cycle over all 64 bits of the distance. One
//   item is in work at a time: a new item is taken only after the last one has
//   left for the output register.
// Reset
//   rst_n clears the registers to their reset values, the margin to 500000 ns
//   and the last missed count to zero; no result is pending after reset.
module adaptive_frame_wake_scheduler
    import afws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIME_W-1:0]   time_now,
    input  logic [NS_W-1:0]     refresh_period,
    input  logic [TIME_W-1:0]   last_scanout,
    input  logic [NS_W-1:0]     pipeline_estimate,
    input  logic [NS_W-1:0]     photon_delay,
    input  logic [NS_W-1:0]     missed_count,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                pacing_active,
    output logic [TIME_W-1:0]   wake_time,
    output logic                sleep_needed,
    output logic [NS_W-1:0]     margin_now,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [NS_W-1:0]     cfg_data
);

    state_t state_reg, state_next;

    logic [NS_W-1:0]   min_margin_reg, min_margin_next;
    logic [NS_W-1:0]   step_up_reg, step_up_next;
    logic [NS_W-1:0]   step_down_reg, step_down_next;
    logic [NS_W-1:0]   margin_reg, margin_next;
    logic [NS_W-1:0]   last_missed_reg, last_missed_next;

    logic [TIME_W-1:0] now_reg, now_next;
    logic [NS_W-1:0]   period_reg, period_next;
    logic [TIME_W-1:0] scan_reg, scan_next;
    logic [NS_W-1:0]   pipe_reg, pipe_next;
    logic [NS_W-1:0]   photon_reg, photon_next;
    logic [NS_W-1:0]   missed_reg, missed_next;
    logic              active_reg, active_next;

    logic [NS_W-1:0]   cap_reg, cap_next;
    logic [NS_W:0]     pp_reg, pp_next;
    logic [NS_W+1:0]   budget_reg, budget_next;
    logic [TIME_W-1:0] reach_reg, reach_next;
    logic [TIME_W-1:0] div_reg, div_next;
    logic [NS_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic              later_reg, later_next;
    logic [TIME_W-1:0] delta_reg, delta_next;

    logic              out_valid_reg, out_valid_next;
    logic              pacing_reg, pacing_next;
    logic [TIME_W-1:0] wake_reg, wake_next;
    logic              sleep_reg, sleep_next;
    logic [NS_W-1:0]   mnow_reg, mnow_next;

    logic              in_take;
    logic              out_free;
    logic              hints_ok;
    logic              div_last;
    logic [NS_W:0]     rem_shift;
    logic [NS_W:0]     up_sum;
    logic [NS_W-1:0]   room;
    logic [NS_W-1:0]   half_period;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign hints_ok  = (time_now != '0) && (refresh_period != '0) && (last_scanout != '0)
                       && (pipeline_estimate != '0) && (photon_delay != '0);
    assign div_last  = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign out_valid     = out_valid_reg;
    assign pacing_active = pacing_reg;
    assign wake_time     = wake_reg;
    assign sleep_needed  = sleep_reg;
    assign margin_now    = mnow_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = hints_ok ? ST_CAP : ST_DONE;
                end
            end
            ST_CAP:        state_next = ST_MARGIN;
            ST_MARGIN:     state_next = ST_BUDGET;
            ST_BUDGET:     state_next = ST_REACH;
            ST_REACH:      state_next = ST_DIFF;
            ST_DIFF:       state_next = (reach_reg > scan_reg) ? ST_DIV : ST_WAKE;
            ST_DIV:        state_next = div_last ? ST_SUB_REM : ST_DIV;
            ST_SUB_REM:    state_next = ST_ADD_PERIOD;
            ST_ADD_PERIOD: state_next = ST_WAKE;
            ST_WAKE:       state_next = ST_SLEEP;
            ST_SLEEP:      state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb
    begin
        min_margin_next  = min_margin_reg;
        step_up_next     = step_up_reg;
        step_down_next   = step_down_reg;
        margin_next      = margin_reg;
        last_missed_next = last_missed_reg;
        now_next         = now_reg;
        period_next      = period_reg;
        scan_next        = scan_reg;
        pipe_next        = pipe_reg;
        photon_next      = photon_reg;
        missed_next      = missed_reg;
        active_next      = active_reg;
        cap_next         = cap_reg;
        pp_next          = pp_reg;
        budget_next      = budget_reg;
        reach_next       = reach_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        t_next           = t_reg;
        later_next       = later_reg;
        delta_next       = delta_reg;
        out_valid_next   = out_valid_reg;
        pacing_next      = pacing_reg;
        wake_next        = wake_reg;
        sleep_next       = sleep_reg;
        mnow_next        = mnow_reg;

        half_period = {1'b0, period_reg[NS_W-1:1]};
        up_sum      = {1'b0, margin_reg} + {1'b0, step_up_reg};
        room        = margin_reg - min_margin_reg;
        rem_shift   = {rem_reg, div_reg[TIME_W-1]};

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_MARGIN: min_margin_next = cfg_data;
                REG_STEP_UP:    step_up_next    = cfg_data;
                REG_STEP_DOWN:  step_down_next  = cfg_data;
                default:        ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    now_next    = time_now;
                    period_next = refresh_period;
                    scan_next   = last_scanout;
                    pipe_next   = pipeline_estimate;
                    photon_next = photon_delay;
                    missed_next = missed_count;
                    active_next = hints_ok;
                end
            end
            ST_CAP:
            begin
                cap_next = (half_period < min_margin_reg) ? min_margin_reg : half_period;
                pp_next  = {1'b0, pipe_reg} + {1'b0, photon_reg};
            end
            ST_MARGIN:
            begin
                if (missed_reg != last_missed_reg)
                begin
                    last_missed_next = missed_reg;
                    margin_next = (up_sum > {1'b0, cap_reg}) ? cap_reg : up_sum[NS_W-1:0];
                end
                else if (margin_reg > min_margin_reg)
                begin
                    margin_next = (room > step_down_reg) ? (margin_reg - step_down_reg)
                                                         : min_margin_reg;
                end
            end
            ST_BUDGET:
            begin
                budget_next = {2'b00, margin_reg} + {1'b0, pp_reg};
            end
            ST_REACH:
            begin
                reach_next = now_reg + {{(TIME_W-NS_W-2){1'b0}}, budget_reg};
            end
            ST_DIFF:
            begin
                // When the target is not beyond the last scanout, the scanout itself is used.
                div_next = reach_reg - scan_reg;
                rem_next = '0;
                cnt_next = '0;
                t_next   = scan_reg;
            end
            ST_DIV:
            begin
                div_next = {div_reg[TIME_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (rem_shift >= {1'b0, period_reg})
                begin
                    rem_next = rem_shift[NS_W-1:0] - period_reg;
                end
                else
                begin
                    rem_next = rem_shift[NS_W-1:0];
                end
            end
            ST_SUB_REM:
            begin
                // Whole periods past the scanout, plus one: reach rounded down, then a period on.
                t_next = reach_reg - {{(TIME_W-NS_W){1'b0}}, rem_reg};
            end
            ST_ADD_PERIOD:
            begin
                t_next = t_reg + {{(TIME_W-NS_W){1'b0}}, period_reg};
            end
            ST_WAKE:
            begin
                t_next = t_reg - {{(TIME_W-NS_W-2){1'b0}}, budget_reg};
            end
            ST_SLEEP:
            begin
                later_next = (t_reg > now_reg);
                delta_next = t_reg - now_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    pacing_next    = active_reg;
                    mnow_next      = margin_reg;
                    if (active_reg)
                    begin
                        wake_next  = t_reg;
                        sleep_next = later_reg && (delta_reg[TIME_W-1:NS_W] == '0)
                                     && (delta_reg[NS_W-1:0] < period_reg);
                    end
                    else
                    begin
                        wake_next  = '0;
                        sleep_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_margin_reg  <= MIN_MARGIN_RST;
            step_up_reg     <= STEP_UP_RST;
            step_down_reg   <= STEP_DOWN_RST;
            margin_reg      <= MARGIN_RST;
            last_missed_reg <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            min_margin_reg  <= min_margin_next;
            step_up_reg     <= step_up_next;
            step_down_reg   <= step_down_next;
            margin_reg      <= margin_next;
            last_missed_reg <= last_missed_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        period_reg <= period_next;
        scan_reg   <= scan_next;
        pipe_reg   <= pipe_next;
        photon_reg <= photon_next;
        missed_reg <= missed_next;
        active_reg <= active_next;
        cap_reg    <= cap_next;
        pp_reg     <= pp_next;
        budget_reg <= budget_next;
        reach_reg  <= reach_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        later_reg  <= later_next;
        delta_reg  <= delta_next;
        pacing_reg <= pacing_next;
        wake_reg   <= wake_next;
        sleep_reg  <= sleep_next;
        mnow_reg   <= mnow_next;
    end

endmodule

### design/afws_checker.sv
// Port-level checker for the adaptive frame wake scheduler, bound to the top level.
// Depends on afws_pkg and adaptive_frame_wake_scheduler_assert.svh.
`include "adaptive_frame_wake_scheduler_assert.svh"

module afws_checker
    import afws_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              pacing_active,
    input logic [TIME_W-1:0] wake_time,
    input logic              sleep_needed,
    input logic              cfg_ready
);

    // A stalled result stays in place until it is taken.
    `AFWS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(wake_time))

    // Once an item is taken the block is busy on the next cycle.
    `AFWS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // Without pacing there is neither a wake time nor a sleep request.
    `AFWS_ASSERT_IMPLY(a_inactive_zero, clk, rst_n, out_valid && !pacing_active, (wake_time == '0) && !sleep_needed)

    // The configuration port never refuses a write.
    `AFWS_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind adaptive_frame_wake_scheduler afws_checker u_afws_checker (.*);
